/* rtl/lphs_pkg.sv */
// shared constants, request/response types and control structs for the hash set
package lphs_pkg;

	localparam int TABLE_SIZE = 1024;
	localparam int KEY_BITS   = 32;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = 11;
	localparam int TOTAL_W    = 32;

	// request type codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic               is_new;
		logic [CNT_W-1:0]   probes;
		logic [TOTAL_W-1:0] total_probes;
		logic               table_full;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_PROBE,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic sweep;
		logic step;
		logic store;
		logic fin_ins;
		logic fin_clr;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic hit;
		logic exhausted;
		logic sweep_last;
	} stat_t;

endpackage

/* rtl/lphs_ram.sv */
// generic single write port, single read port ram with registered read
module lphs_ram #(
	parameter int Width = 33,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lphs_dp.sv */
// datapath: slot memory, probe position and count, probe total, result registers
module lphs_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  lphs_pkg::cmd_t  cmd,
	input  lphs_pkg::req_t  req,
	output lphs_pkg::stat_t stat,
	output lphs_pkg::rsp_t  rsp
);
	import lphs_pkg::*;

	logic [IDX_W-1:0]    pos_q;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    raddr;
	logic [IDX_W-1:0]    waddr;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    count_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  total_nxt;
	logic [TOTAL_W:0]    sum;
	logic                we;
	logic [KEY_BITS:0]   wdata;
	logic [KEY_BITS:0]   rdata;
	rsp_t                res_q;
	rsp_t                rsp_q;

	// read the home slot on accept, else the slot after the current one
	assign raddr = cmd.start ? req.key[IDX_W-1:0] : pos_q + IDX_W'(1);

	// sweep writes empty slots, an insert stores the key with its valid bit
	assign we    = cmd.sweep | cmd.store;
	assign waddr = cmd.sweep ? clr_q : pos_q;
	assign wdata = cmd.sweep ? '0 : {1'b1, key_q};

	lphs_ram #(
		.Width (KEY_BITS + 1),
		.Depth (TABLE_SIZE)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// slot status for the controller
	assign stat.empty      = !rdata[KEY_BITS];
	assign stat.hit        = rdata[KEY_BITS] && (rdata[KEY_BITS-1:0] == key_q);
	assign stat.exhausted  = (count_q == CNT_W'(TABLE_SIZE));
	assign stat.sweep_last = (clr_q == IDX_W'(TABLE_SIZE - 1));

	// saturating probe total
	assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(count_q);
	assign total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

	// probe walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start) begin
			count_q <= CNT_W'(1);
		end else if (cmd.step) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= req.key;
			pos_q <= req.key[IDX_W-1:0];
		end else if (cmd.step) begin
			pos_q <= pos_q + IDX_W'(1);
		end
	end

	// sweep address counter, wraps back to zero at the end of a sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.sweep) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	// running probe total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.fin_clr) begin
			total_q <= '0;
		end else if (cmd.fin_ins) begin
			total_q <= total_nxt;
		end
	end

	// finished result, then the output register
	always_ff @(posedge clk) begin
		if (cmd.fin_clr) begin
			res_q <= '0;
		end else if (cmd.fin_ins) begin
			res_q.is_new       <= stat.empty;
			res_q.probes       <= count_q;
			res_q.total_probes <= total_nxt;
			res_q.table_full   <= !stat.empty && !stat.hit;
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

endmodule

/* rtl/lphs_ctrl.sv */
// controller: state machine for sweep, probe walk and response handoff
module lphs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_type,
	input  logic            rsp_stall,
	input  lphs_pkg::stat_t stat,
	output logic            req_stall,
	output logic            rsp_valid,
	output lphs_pkg::cmd_t  cmd
);
	import lphs_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   clr_pend_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   done;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign done     = stat.empty | stat.hit | stat.exhausted;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLR: begin
				if (stat.sweep_last) begin
					state_nxt = clr_pend_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = (req_type == REQ_CLEAR) ? ST_CLR : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (done) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLR;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_CLR: begin
				cmd.sweep   = 1'b1;
				cmd.fin_clr = stat.sweep_last && clr_pend_q;
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.start = req_valid && (req_type == REQ_INSERT);
			end
			ST_PROBE: begin
				cmd.store   = stat.empty;
				cmd.step    = !done;
				cmd.fin_ins = done;
			end
			ST_RESP: begin
				cmd.load_out = out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// state and pending clear request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_pend_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && req_valid && req_type == REQ_CLEAR) begin
				clr_pend_q <= 1'b1;
			end else if (state_q == ST_CLR && stat.sweep_last) begin
				clr_pend_q <= 1'b0;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/linear_probe_hash_set.sv */
// top level: deduplicating hash set with linear probing over a 1024-slot table
//
// Requests arrive on req (req_valid/req_stall): an insert carries a 32-bit key,
// a clear empties the table and zeroes the probe total. Each request gives one
// response on rsp (rsp_valid/rsp_stall) with is_new, probes, the saturating
// probe total and table_full. A request is taken when valid is high and stall
// is low; one request is in work at a time.
// Insert: each probe is one read of the single read port of the slot memory;
// the result is loaded into the output register once the receiver is free,
// and only then is the next request taken. A full table with the key absent
// takes 1024 probes.
// Clear: the slot memory is swept one slot per cycle over all 1024 slots; the
// response is loaded after the last slot and the next request is taken after that.
// After reset the same sweep runs with req_stall high, and the probe total is
// zero. A stalled response holds in the output register; a new request is
// still taken and worked on, and waits for the register to free.
module linear_probe_hash_set (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lphs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lphs_pkg::rsp_t rsp
);
	import lphs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lphs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.cmd       (cmd)
	);

	lphs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.stat   (stat),
		.rsp    (rsp)
	);

`ifndef ASSERT_OFF
	// a full table reports every slot examined
	a_full_probes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.table_full |-> rsp.probes == CNT_W'(TABLE_SIZE))
		else $error("table_full without a full probe count");

	// a stored key never comes with a full table
	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_new |-> !rsp.table_full && rsp.probes != '0)
		else $error("new key flagged full or with no probes");

	// the block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in work");

	// a response never appears without a request in work before it
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response raised while idle");
`endif

endmodule

/* tb/linear_probe_hash_set_tb.sv */
// testbench for linear_probe_hash_set: queued requests, shadow hash set, in-order response check
`timescale 1ns / 1ps

module linear_probe_hash_set_tb;
	import lphs_pkg::*;

	localparam int CYCLE_LIMIT  = 500_000;
	localparam int DRAIN_CYCLES = 50;
	localparam int HOLD_CYCLES  = 300;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	linear_probe_hash_set u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the table and the probe total
	bit [KEY_BITS-1:0] shadow_key  [TABLE_SIZE];
	bit                shadow_used [TABLE_SIZE];
	bit [TOTAL_W-1:0]  shadow_total = '0;

	req_t              req_backlog [$];
	rsp_t              due_rsp     [$];
	bit [KEY_BITS-1:0] queued_keys [$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          hold_arm    = 1'b0;
	bit          hold_done;
	int unsigned hold_left;
	int unsigned cycles      = 0;
	int unsigned mismatches  = 0;
	int unsigned rsp_seen    = 0;
	int unsigned n_accepted  = 0;
	int unsigned n_clears    = 0;
	int unsigned n_dups      = 0;
	int unsigned n_full      = 0;
	int unsigned max_probes  = 0;
	rsp_t        model_rsp;

	// walk the shadow table for one request, updating it as the block would
	function automatic rsp_t probe_and_insert(input req_t r);
		rsp_t            res;
		int unsigned     pos;
		int unsigned     count;
		bit              stored;
		bit              found;
		longint unsigned sum;
		res = '0;
		if (r.req_type == REQ_CLEAR) begin
			foreach (shadow_used[i])
				shadow_used[i] = 1'b0;
			shadow_total = '0;
			return res;
		end
		pos    = r.key % TABLE_SIZE;
		count  = 0;
		stored = 1'b0;
		found  = 1'b0;
		while (count < TABLE_SIZE && !stored && !found) begin
			count++;
			if (!shadow_used[pos]) begin
				shadow_used[pos] = 1'b1;
				shadow_key[pos]  = r.key;
				stored           = 1'b1;
			end else if (shadow_key[pos] == r.key) begin
				found = 1'b1;
			end else begin
				pos = (pos == TABLE_SIZE - 1) ? 0 : pos + 1;
			end
		end
		sum = 64'(shadow_total) + 64'(count);
		shadow_total     = (sum > 64'({TOTAL_W{1'b1}})) ? '1 : sum[TOTAL_W-1:0];
		res.is_new       = stored;
		res.probes       = CNT_W'(count);
		res.total_probes = shadow_total;
		res.table_full   = !stored && !found;
		return res;
	endfunction

	// request driver: predicts at acceptance, then offers the next request or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				model_rsp = probe_and_insert(req);
				due_rsp.push_back(model_rsp);
				n_accepted++;
				if (req.req_type == REQ_CLEAR)
					n_clears++;
				else if (!model_rsp.is_new && !model_rsp.table_full)
					n_dups++;
				if (model_rsp.table_full)
					n_full++;
				if (32'(model_rsp.probes) > max_probes)
					max_probes = 32'(model_rsp.probes);
			end
			if (!req_valid || !req_stall) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// compare one response against the oldest prediction
	task automatic check_response(input rsp_t got);
		rsp_t exp;
		rsp_seen++;
		if (due_rsp.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"response %0d arrived with no request outstanding: ",
					"is_new=%0b probes=%0d total=%0d full=%0b"},
					rsp_seen, got.is_new, got.probes, got.total_probes, got.table_full);
			return;
		end
		exp = due_rsp.pop_front();
		if (got.is_new !== exp.is_new || got.probes !== exp.probes ||
		    got.total_probes !== exp.total_probes || got.table_full !== exp.table_full) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"response %0d mismatch: ",
					"expected is_new=%0b probes=%0d total=%0d full=%0b, ",
					"got is_new=%0b probes=%0d total=%0d full=%0b"},
					rsp_seen, exp.is_new, exp.probes, exp.total_probes, exp.table_full,
					got.is_new, got.probes, got.total_probes, got.table_full);
		end
	endtask

	// response monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
			rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// long receiver hold-off, armed once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic queue_req(input logic kind, input bit [KEY_BITS-1:0] k);
		req_t r;
		r.req_type = kind;
		r.key      = k;
		req_backlog.push_back(r);
		if (kind == REQ_CLEAR)
			queued_keys.delete();
		else
			queued_keys.push_back(k);
	endtask

	// mix of clears, clustered keys (chains, wrap at the table end), repeats and random keys
	task automatic queue_random(input int n);
		bit [KEY_BITS-1:0] k;
		int unsigned       pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			k    = $urandom;
			if (pick < 4) begin
				queue_req(REQ_CLEAR, k);
			end else begin
				if (pick < 25)
					k[IDX_W-1:0] = IDX_W'($urandom_range(0, 23));
				else if (pick < 45)
					k[IDX_W-1:0] = IDX_W'(TABLE_SIZE - 1 - $urandom_range(0, 23));
				else if (pick < 75 && queued_keys.size() != 0)
					k = queued_keys[$urandom_range(0, queued_keys.size() - 1)];
				queue_req(REQ_INSERT, k);
			end
		end
	endtask

	task automatic wait_drained();
		while (req_backlog.size() != 0 || req_valid || due_rsp.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		bit [KEY_BITS-1:0] k;
		foreach (shadow_used[i])
			shadow_used[i] = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// phase 0: sender idles a little, receiver a lot; directed requests first
		tx_idle_pct = 28;
		rx_idle_pct = 81;
		queue_req(REQ_INSERT, 32'h0000_0000);
		queue_req(REQ_INSERT, 32'hFFFF_FFFF);
		queue_req(REQ_INSERT, 32'h0000_0000);   // duplicate
		queue_req(REQ_INSERT, 32'h0000_0400);   // collides at slot 0
		queue_req(REQ_INSERT, 32'h0000_0800);
		queue_req(REQ_INSERT, 32'h0000_07FF);   // home at the last slot, wraps to the front
		queue_req(REQ_INSERT, 32'hFFFF_FFFF);
		queue_req(REQ_INSERT, 32'h0000_07FF);
		queue_req(REQ_INSERT, 32'h8000_0001);
		queue_req(REQ_INSERT, 32'hAAAA_AAAA);
		queue_req(REQ_INSERT, 32'h5555_5555);
		queue_req(REQ_CLEAR,  32'hFFFF_FFFF);
		queue_req(REQ_INSERT, 32'h0000_0000);
		queue_req(REQ_CLEAR,  32'h0000_0000);
		queue_req(REQ_CLEAR,  32'h1234_5678);   // back-to-back clears
		queue_req(REQ_INSERT, 32'h1234_5678);
		queue_random(50);
		wait_drained();

		// phase 1: roles swapped
		tx_idle_pct = 81;
		rx_idle_pct = 28;
		queue_random(60);
		wait_drained();

		// phase 2: no idling; receiver holds off once as the phase starts, then the table is filled
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_arm    = 1'b1;
		queue_req(REQ_CLEAR, $urandom);
		for (int i = 0; i < TABLE_SIZE; i++) begin
			k = $urandom;
			k[KEY_BITS-1]  = 1'b0;
			k[IDX_W-1:0]   = IDX_W'(i);
			queue_req(REQ_INSERT, k);
		end
		// full table: absent keys walk every slot, present ones still hit
		k = $urandom;
		k[KEY_BITS-1] = 1'b1;
		k[IDX_W-1:0]  = '0;
		queue_req(REQ_INSERT, k);
		queue_req(REQ_INSERT, queued_keys[$urandom_range(0, TABLE_SIZE - 1)]);
		k = $urandom;
		k[KEY_BITS-1] = 1'b1;
		k[IDX_W-1:0]  = '1;
		queue_req(REQ_INSERT, k);
		queue_req(REQ_INSERT, queued_keys[TABLE_SIZE - 1]);
		queue_req(REQ_CLEAR, $urandom);
		queue_random(20);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests checked: %0d clears, %0d duplicate inserts, %0d full-table misses",
			n_accepted, n_clears, n_dups, n_full);
		$display("longest probe walk %0d slots, %0d mismatches, %0d cycles",
			max_probes, mismatches, cycles);
		if (mismatches == 0 && due_rsp.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
